>>> src/can_sensor_frame_signal_decoder_assert.svh
// assertion macros for the can sensor frame decoder checker
// depends on clk_i and rst_ni being visible where the macros are used
`ifndef CAN_SENSOR_FRAME_SIGNAL_DECODER_ASSERT_SVH
`define CAN_SENSOR_FRAME_SIGNAL_DECODER_ASSERT_SVH

// same-cycle implication
`define CSD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/csd_pkg.sv
// shared types, constants and signal table of the can sensor frame decoder
// no dependencies
package csd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 4;
  localparam int VAL_W     = 48;
  localparam int SH_W      = $clog2(FRAC_BITS + 1);
  localparam int CNT_W     = 3;
  // frame control stages: input register plus the five lane stages
  localparam int NUM_STG   = 6;

  localparam logic [10:0] ID_VEL  = 11'h7E0;
  localparam logic [10:0] ID_DIST = 11'h7E1;
  localparam logic [10:0] ID_ATT  = 11'h7E2;
  localparam logic [10:0] ID_RATE = 11'h7E7;

  // seen flag bits
  localparam logic [2:0] SEEN_TIME = 3'b001;
  localparam logic [2:0] SEEN_VEL  = 3'b010;
  localparam logic [2:0] SEEN_DIST = 3'b100;
  localparam logic [2:0] SEEN_ALL  = 3'b111;

  // odd part of the divisor; the power-of-two part lives in the shift
  localparam logic [6:0] ODD_125 = 7'd125;
  localparam logic [6:0] ODD_25  = 7'd25;
  localparam logic [5:0] HALF_125 = 6'd62;
  localparam logic [5:0] HALF_25  = 6'd12;

  // reciprocals, exact floor division for 32-bit (first) and 31-bit (second) dividends
  localparam logic [32:0] RCP1_125 = 33'd4398046512;
  localparam int          RSH1_125 = 39;
  localparam logic [32:0] RCP1_25  = 33'd5497558139;
  localparam int          RSH1_25  = 37;
  localparam logic [31:0] RCP2_125 = 32'd2199023256;
  localparam int          RSH2_125 = 38;
  localparam logic [31:0] RCP2_25  = 32'd2748779070;
  localparam int          RSH2_25  = 36;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_VEL,
    KIND_DIST,
    KIND_ATT,
    KIND_RATE
  } frame_kind_e;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_25,
    DIV_125
  } div_sel_e;

  typedef struct packed {
    logic [3:0] code;
    logic       wide;   // four-byte field
    logic       sgn;    // ones' complement signed
    logic       x9;     // numerator 9
    div_sel_e   div;
    logic [1:0] k;      // power-of-two part of the denominator
  } sig_def_t;

  typedef struct packed {
    logic [3:0]       code;
    logic             neg;
    logic [VAL_W-1:0] sum;
  } lane_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             complete;
  } csd_frame_t;

  function automatic sig_def_t mk_def(logic [3:0] code, logic wide, logic sgn,
                                      logic x9, div_sel_e div, logic [1:0] k);
    sig_def_t d;
    d.code = code;
    d.wide = wide;
    d.sgn  = sgn;
    d.x9   = x9;
    d.div  = div;
    d.k    = k;
    return d;
  endfunction

  // signal table: lane j handles the signal starting at byte 2*j
  function automatic sig_def_t lane_def(frame_kind_e kind, logic [1:0] lane);
    sig_def_t d;
    d = mk_def(4'd0, 1'b0, 1'b0, 1'b0, DIV_1, 2'd0);
    case (kind)
      KIND_VEL: begin
        case (lane)
          2'd0: d = mk_def(4'd5, 1'b0, 1'b1, 1'b1, DIV_125, 2'd1);
          2'd1: d = mk_def(4'd6, 1'b0, 1'b1, 1'b1, DIV_125, 2'd1);
          2'd2: d = mk_def(4'd7, 1'b0, 1'b1, 1'b1, DIV_125, 2'd1);
          default: d = mk_def(4'd8, 1'b0, 1'b1, 1'b0, DIV_25, 2'd2);
        endcase
      end
      KIND_DIST: d = mk_def(4'd4, 1'b1, 1'b1, 1'b0, DIV_125, 2'd3);
      KIND_ATT: begin
        case (lane)
          2'd0: d = mk_def(4'd0, 1'b0, 1'b1, 1'b0, DIV_25, 2'd2);
          2'd1: d = mk_def(4'd1, 1'b0, 1'b1, 1'b0, DIV_25, 2'd2);
          2'd2: d = mk_def(4'd2, 1'b0, 1'b0, 1'b0, DIV_1, 2'd0);
          default: d = mk_def(4'd3, 1'b0, 1'b0, 1'b0, DIV_25, 2'd2);
        endcase
      end
      KIND_RATE: begin
        case (lane)
          2'd0: d = mk_def(4'd9, 1'b0, 1'b1, 1'b0, DIV_25, 2'd1);
          2'd1: d = mk_def(4'd10, 1'b0, 1'b1, 1'b0, DIV_25, 2'd1);
          default: d = mk_def(4'd11, 1'b0, 1'b1, 1'b0, DIV_25, 2'd1);
        endcase
      end
      default: d = mk_def(4'd0, 1'b0, 1'b0, 1'b0, DIV_1, 2'd0);
    endcase
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] kind_count(frame_kind_e kind);
    logic [CNT_W-1:0] n;
    case (kind)
      KIND_VEL:  n = CNT_W'(4);
      KIND_DIST: n = CNT_W'(1);
      KIND_ATT:  n = CNT_W'(4);
      KIND_RATE: n = CNT_W'(3);
      default:   n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] kind_seen(frame_kind_e kind);
    logic [2:0] s;
    case (kind)
      KIND_VEL:  s = SEEN_VEL;
      KIND_DIST: s = SEEN_DIST;
      KIND_ATT:  s = SEEN_TIME;
      default:   s = 3'b000;
    endcase
    return s;
  endfunction

endpackage

>>> src/can_sensor_frame_signal_decoder.sv
// top level of the can sensor frame decoder: input register, seen flags,
// four decode lanes and the merge stage; uses csd_pkg, csd_lane, csd_merge
//
//   channel  handshake                  fields
//   in       in_valid_i / in_stall_o    frame_id_i, payload_i
//   out      out_valid_o / out_stall_i  signal_code_o, value_o, last_o, record_complete_o
//
// the first output beat of a frame is offered from the merge register
// (input register, five lane stages, merge register); a stall can hold it on the way
// a frame with n signals, four at most, holds the merge stage until its n beats have
// left, and the pipe takes the next frame only as the last beat leaves
// reset clears the seen flags, the stage valids and the merge count
// a stall on the output freezes the whole pipe and shows up on in_stall_o
module can_sensor_frame_signal_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [10:0]         frame_id_i,
  input  logic [63:0]         payload_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          signal_code_o,
  output logic signed [47:0]  value_o,
  output logic                last_o,
  output logic                record_complete_o
);
  import csd_pkg::*;

  logic adv;          // whole pipe moves one stage
  logic accept;
  assign in_stall_o = ~adv;
  assign accept     = in_valid_i & adv;

  // identifier lookup
  frame_kind_e kind_d;
  always_comb begin
    case (frame_id_i)
      ID_VEL:  kind_d = KIND_VEL;
      ID_DIST: kind_d = KIND_DIST;
      ID_ATT:  kind_d = KIND_ATT;
      ID_RATE: kind_d = KIND_RATE;
      default: kind_d = KIND_NONE;
    endcase
  end

  // seen flags, updated in frame order at the input beat
  logic [2:0] seen_q, seen_d, seen_upd;
  logic       cmpl_d;

  always_comb begin
    seen_upd = seen_q | kind_seen(kind_d);
    cmpl_d   = (seen_upd == SEEN_ALL);
    seen_d   = seen_q;
    if (accept) begin
      seen_d = cmpl_d ? 3'b000 : seen_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 3'b000;
    end else begin
      seen_q <= seen_d;
    end
  end

  // per-stage frame control: valid, result count, completion
  logic [NUM_STG-1:0] vld_q;
  csd_frame_t         frm_q [NUM_STG];
  csd_frame_t         frm_in;

  assign frm_in.cnt      = kind_count(kind_d);
  assign frm_in.complete = cmpl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int i = 0; i < NUM_STG; i++) begin
        frm_q[i] <= '0;
      end
    end else if (adv) begin
      vld_q    <= {vld_q[NUM_STG-2:0], in_valid_i};
      frm_q[0] <= frm_in;
      for (int i = 1; i < NUM_STG; i++) begin
        frm_q[i] <= frm_q[i-1];
      end
    end
  end

  // input register for the payload and the frame kind
  logic [63:0] payload_q;
  frame_kind_e kind_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      payload_q <= payload_i;
      kind_q    <= kind_d;
    end
  end

  // lanes: lane j looks at bytes 2j upward, zero above byte 7
  logic [79:0] payload_ext;
  lane_res_t   lane_res [NUM_LANES];

  assign payload_ext = {16'b0, payload_q};

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    csd_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .raw_i (payload_ext[16*j +: 32]),
      .def_i (lane_def(kind_q, 2'(j))),
      .res_o (lane_res[j])
    );
  end

  // frames without signals are dropped here
  logic load;
  assign load = vld_q[NUM_STG-1] & (frm_q[NUM_STG-1].cnt != '0);

  csd_merge u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (load),
    .frame_i           (frm_q[NUM_STG-1]),
    .res_i             (lane_res),
    .free_o            (adv),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .signal_code_o     (signal_code_o),
    .value_o           (value_o),
    .last_o            (last_o),
    .record_complete_o (record_complete_o)
  );

endmodule

>>> src/csd_lane.sv
// one decode lane: field extraction, ones' complement, scaling with rounding
// five register stages, uses csd_pkg
module csd_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         raw_i,
  input  csd_pkg::sig_def_t   def_i,
  output csd_pkg::lane_res_t  res_o
);
  import csd_pkg::*;

  typedef struct packed {
    logic [3:0] code;
    logic       neg;
    div_sel_e   div;
    logic [1:0] k;
  } tag_t;

  // stage 1: magnitude times numerator
  logic [31:0] mag, a1_d, a1_q;
  tag_t        tag1_d, tag1_q;
  logic        top_bit;

  always_comb begin
    top_bit = def_i.wide ? raw_i[31] : raw_i[15];
    tag1_d.code = def_i.code;
    tag1_d.neg  = def_i.sgn & top_bit;
    tag1_d.div  = def_i.div;
    tag1_d.k    = def_i.k;
    if (def_i.wide) begin
      mag = tag1_d.neg ? ~raw_i : raw_i;
    end else begin
      mag = {16'b0, (tag1_d.neg ? ~raw_i[15:0] : raw_i[15:0])};
    end
    a1_d = def_i.x9 ? 32'({mag, 3'b000} + 35'(mag)) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a1_d;
      tag1_q <= tag1_d;
    end
  end

  // stage 2: coarse quotient by the odd divisor
  logic [64:0] prod1;
  logic [31:0] qa2_d, qa2_q, a2_q;
  tag_t        tag2_q;

  always_comb begin
    prod1 = '0;
    qa2_d = a1_q;
    case (tag1_q.div)
      DIV_125: begin
        prod1 = 65'(a1_q) * 65'(RCP1_125);
        qa2_d = 32'(prod1 >> RSH1_125);
      end
      DIV_25: begin
        prod1 = 65'(a1_q) * 65'(RCP1_25);
        qa2_d = 32'(prod1 >> RSH1_25);
      end
      default: qa2_d = a1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa2_q  <= qa2_d;
      a2_q   <= a1_q;
      tag2_q <= tag1_q;
    end
  end

  // stage 3: remainder of the coarse division
  logic [6:0]  ra3_d, ra3_q;
  logic [31:0] qa3_q;
  tag_t        tag3_q;

  always_comb begin
    case (tag2_q.div)
      DIV_125: ra3_d = 7'(a2_q - 32'(qa2_q * 32'(ODD_125)));
      DIV_25:  ra3_d = 7'(a2_q - 32'(qa2_q * 32'(ODD_25)));
      default: ra3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra3_q  <= ra3_d;
      qa3_q  <= qa2_q;
      tag3_q <= tag2_q;
    end
  end

  // stage 4: fraction part, remainder shifted up plus half, divided again
  logic [SH_W-1:0] sh3;
  logic [30:0]     z;
  logic [62:0]     prod2;
  logic [30:0]     qb4_d, qb4_q;
  logic [31:0]     qa4_q;
  logic [SH_W-1:0] sh4_q;
  tag_t            tag4_q;

  always_comb begin
    sh3   = SH_W'(FRAC_BITS) - SH_W'(tag3_q.k);
    z     = 31'(ra3_q) << sh3;
    prod2 = '0;
    case (tag3_q.div)
      DIV_125: begin
        prod2 = 63'(z + 31'(HALF_125)) * 63'(RCP2_125);
        qb4_d = 31'(prod2 >> RSH2_125);
      end
      DIV_25: begin
        prod2 = 63'(z + 31'(HALF_25)) * 63'(RCP2_25);
        qb4_d = 31'(prod2 >> RSH2_25);
      end
      default: qb4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qb4_q  <= qb4_d;
      qa4_q  <= qa3_q;
      sh4_q  <= sh3;
      tag4_q <= tag3_q;
    end
  end

  // stage 5: integer part shifted into place plus fraction part
  logic [VAL_W-1:0] sum5_d, sum5_q;
  tag_t             tag5_q;

  assign sum5_d = (VAL_W'(qa4_q) << sh4_q) + VAL_W'(qb4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum5_q <= sum5_d;
      tag5_q <= tag4_q;
    end
  end

  assign res_o.code = tag5_q.code;
  assign res_o.neg  = tag5_q.neg;
  assign res_o.sum  = sum5_q;

endmodule

>>> src/csd_merge.sv
// merge stage: takes all lane results of one frame and sends them one beat at a time
// uses csd_pkg
module csd_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  csd_pkg::csd_frame_t frame_i,
  input  csd_pkg::lane_res_t  res_i [csd_pkg::NUM_LANES],
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          signal_code_o,
  output logic signed [47:0]  value_o,
  output logic                last_o,
  output logic                record_complete_o
);
  import csd_pkg::*;

  logic [CNT_W-1:0] rem_q;
  logic [1:0]       ptr_q;
  logic             cmpl_q;
  logic [VAL_W-1:0] val_q [NUM_LANES];
  logic [3:0]       code_q [NUM_LANES];
  logic             fire, take;

  assign out_valid_o = (rem_q != '0);
  assign fire        = out_valid_o & ~out_stall_i;
  assign free_o      = (rem_q == '0) | (fire & (rem_q == CNT_W'(1)));
  assign take        = load_i & free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      ptr_q  <= '0;
      cmpl_q <= 1'b0;
    end else if (take) begin
      rem_q  <= frame_i.cnt;
      ptr_q  <= '0;
      cmpl_q <= frame_i.complete;
    end else if (fire) begin
      rem_q <= rem_q - CNT_W'(1);
      ptr_q <= ptr_q + 2'd1;
    end
  end

  // sign applied on the way in
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        val_q[i]  <= res_i[i].neg ? (VAL_W'(0) - res_i[i].sum) : res_i[i].sum;
        code_q[i] <= res_i[i].code;
      end
    end
  end

  assign signal_code_o     = code_q[ptr_q];
  assign value_o           = val_q[ptr_q];
  assign last_o            = (rem_q == CNT_W'(1));
  assign record_complete_o = last_o & cmpl_q;

endmodule

>>> src/csd_checker.sv
// port-level checker for the can sensor frame decoder, bound to the top level
// depends on can_sensor_frame_signal_decoder_assert.svh
module csd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [3:0]         signal_code_o,
  input logic signed [47:0] value_o,
  input logic               last_o,
  input logic               record_complete_o
);
`include "can_sensor_frame_signal_decoder_assert.svh"

  // stalled output beat holds
  `CSD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o) && $stable(signal_code_o) && $stable(last_o), "stalled output beat changed")

  // completion only on the last beat of a frame
  `CSD_ASSERT_IMP(a_cmpl_last, out_valid_o && record_complete_o, last_o, "record complete without last")

  // a frame's beats come without gaps
  `CSD_ASSERT_NXT(a_no_gap, out_valid_o && !out_stall_i && !last_o, out_valid_o, "gap inside a frame")

  // only known signal codes leave the block
  `CSD_ASSERT_IMP(a_code_range, out_valid_o, signal_code_o <= 4'd11, "signal code out of range")

  // input holds off only while an output beat is waiting
  `CSD_ASSERT_IMP(a_stall_busy, in_stall_o, out_valid_o, "input stalled with nothing to send")

endmodule

bind can_sensor_frame_signal_decoder csd_checker u_csd_checker (.*);

>>> tb/can_sensor_frame_signal_decoder_test.sv
// self-checking bench for the can sensor frame decoder: table of directed frames, then random
// frames, every output beat checked against a frame decoder kept in this file
// depends on csd_pkg and can_sensor_frame_signal_decoder
module can_sensor_frame_signal_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  localparam int RANDOM_FRAMES = 445;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 90;
  localparam int DRAIN_CYCLES  = 20;
  localparam int NUM_DIRECTED  = 25;

  // signal codes as they appear on signal_code_o
  typedef enum logic [3:0] {
    SIG_PITCH,
    SIG_ROLL,
    SIG_TIME,
    SIG_RADIUS,
    SIG_DISTANCE,
    SIG_VEL_X,
    SIG_VEL_Y,
    SIG_VEL,
    SIG_ANGLE,
    SIG_RATE_X,
    SIG_RATE_Y,
    SIG_RATE_Z
  } sig_code_e;

  typedef struct packed {
    sig_code_e          code;
    logic signed [47:0] value;
    logic               last;
    logic               complete;
  } sig_beat_t;

  // one frame of stimulus; typed rows carry the known result of a distance frame
  typedef struct packed {
    logic [10:0]        id;
    logic [63:0]        payload;
    logic               typed;
    logic signed [47:0] t_value;
    logic               t_complete;
  } frame_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [10:0]        frame_id_i;
  logic [63:0]        payload_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [3:0]         signal_code_o;
  logic signed [47:0] value_o;
  logic               last_o;
  logic               record_complete_o;

  can_sensor_frame_signal_decoder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .frame_id_i        (frame_id_i),
    .payload_i         (payload_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .signal_code_o     (signal_code_o),
    .value_o           (value_o),
    .last_o            (last_o),
    .record_complete_o (record_complete_o)
  );

  // decoder state mirrored here: time, velocity and distance seen flags
  logic [2:0]  seen_mask = 3'b000;
  sig_beat_t   pending_signals[$];
  int          errors = 0;
  int          frames_sent = 0;
  int          unknown_sent = 0;
  int          beats_checked = 0;
  int          records_done = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;      // no random idle gaps are drawn on either side while set
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off

  // 16-bit patterns worth hitting in every field: zeros, ones, sign edges, negative zero
  localparam logic [15:0] FIELD_CORNERS [6] = '{
    16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF
  };

  frame_row_t directed_rows [NUM_DIRECTED] = '{
    // distance right after reset: zero, negative zero, +1000 and -1000 raw counts
    '{ID_DIST, 64'h0000_0000_0000_0000, 1'b1, 48'sd0, 1'b0},
    '{ID_DIST, 64'h0000_0000_FFFF_FFFF, 1'b1, 48'sd0, 1'b0},
    '{ID_DIST, 64'h0000_0000_0000_03E8, 1'b1, 48'sd65536, 1'b0},
    // upper bytes must be ignored by the distance field
    '{ID_DIST, 64'hFFFF_FFFF_FFFF_FC17, 1'b1, -48'sd65536, 1'b0},
    // ids with no signals, some close to the known ones
    '{11'h000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{11'h7E3, 64'h0000_0000_0000_0000, 1'b0, 48'sd0, 1'b0},
    '{11'h7E8, 64'h0123_4567_89AB_CDEF, 1'b0, 48'sd0, 1'b0},
    '{11'h3E0, 64'h8000_7FFF_8000_7FFF, 1'b0, 48'sd0, 1'b0},
    // velocity, attitude and rate at the field extremes; attitude completes the record
    '{ID_VEL,  64'h8000_7FFF_8000_7FFF, 1'b0, 48'sd0, 1'b0},
    '{ID_VEL,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ID_ATT,  64'hFFFF_FFFF_8000_7FFF, 1'b0, 48'sd0, 1'b0},
    '{ID_ATT,  64'h0000_0000_0000_0000, 1'b0, 48'sd0, 1'b0},
    '{ID_RATE, 64'h1234_8000_7FFF_0001, 1'b0, 48'sd0, 1'b0},
    '{ID_RATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ID_ATT,  64'h00FF_0001_FFFE_0100, 1'b0, 48'sd0, 1'b0},
    // unknown id in the middle of a record leaves the flags alone
    '{11'h7E4, 64'hA5A5_5A5A_A5A5_5A5A, 1'b0, 48'sd0, 1'b0},
    '{ID_VEL,  64'h0001_FFFE_0001_FFFE, 1'b0, 48'sd0, 1'b0},
    // distance closes the record here, and the next one starts fresh
    '{ID_DIST, 64'h0000_0000_0000_03E8, 1'b1, 48'sd65536, 1'b1},
    '{ID_DIST, 64'h0000_0000_FFFF_FC17, 1'b1, -48'sd65536, 1'b0},
    '{ID_DIST, 64'h0000_0000_7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ID_DIST, 64'h0000_0000_8000_0000, 1'b0, 48'sd0, 1'b0},
    '{ID_ATT,  64'hFFFF_0000_0000_0000, 1'b0, 48'sd0, 1'b0},
    '{ID_RATE, 64'h0001_FFFE_0001_FFFE, 1'b0, 48'sd0, 1'b0},
    '{ID_VEL,  64'h7FFF_8000_FFFE_0001, 1'b0, 48'sd0, 1'b0}
  };

  // byte-aligned field, ones' complement when signed, times fnum/fden into fixed point,
  // halves rounded away from zero
  function automatic logic signed [47:0] scale_field(logic [63:0] p, int byte0, int nbytes,
                                                     logic sgn, int fnum, int fden);
    logic [63:0] full;
    logic [63:0] raw;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] q;
    logic        neg;
    full = (64'd1 << (nbytes * 8)) - 64'd1;
    raw  = (p >> (byte0 * 8)) & full;
    neg  = sgn && raw[nbytes * 8 - 1];
    mag  = neg ? full - raw : raw;
    num  = (mag * 64'(fnum)) << FRAC_BITS;
    q    = (64'd2 * num + 64'(fden)) / (64'd2 * 64'(fden));
    if (neg) q = -q;
    return q[47:0];
  endfunction

  // signals of one frame in output order; updates the seen flags
  function automatic void decode_frame(input logic [10:0] id, input logic [63:0] p,
                                       output sig_beat_t beats [4], output int n);
    logic [2:0] flag;
    logic       done;
    n    = 0;
    flag = 3'b000;
    case (id)
      ID_VEL: begin
        beats[0] = '{SIG_VEL_X, scale_field(p, 0, 2, 1'b1, 9, 250), 1'b0, 1'b0};
        beats[1] = '{SIG_VEL_Y, scale_field(p, 2, 2, 1'b1, 9, 250), 1'b0, 1'b0};
        beats[2] = '{SIG_VEL,   scale_field(p, 4, 2, 1'b1, 9, 250), 1'b0, 1'b0};
        beats[3] = '{SIG_ANGLE, scale_field(p, 6, 2, 1'b1, 1, 100), 1'b0, 1'b0};
        n        = 4;
        flag     = SEEN_VEL;
      end
      ID_DIST: begin
        beats[0] = '{SIG_DISTANCE, scale_field(p, 0, 4, 1'b1, 1, 1000), 1'b0, 1'b0};
        n        = 1;
        flag     = SEEN_DIST;
      end
      ID_ATT: begin
        beats[0] = '{SIG_PITCH,  scale_field(p, 0, 2, 1'b1, 1, 100), 1'b0, 1'b0};
        beats[1] = '{SIG_ROLL,   scale_field(p, 2, 2, 1'b1, 1, 100), 1'b0, 1'b0};
        beats[2] = '{SIG_TIME,   scale_field(p, 4, 2, 1'b0, 1, 1),   1'b0, 1'b0};
        beats[3] = '{SIG_RADIUS, scale_field(p, 6, 2, 1'b0, 1, 100), 1'b0, 1'b0};
        n        = 4;
        flag     = SEEN_TIME;
      end
      ID_RATE: begin
        // angular rates count toward no record
        beats[0] = '{SIG_RATE_X, scale_field(p, 0, 2, 1'b1, 1, 50), 1'b0, 1'b0};
        beats[1] = '{SIG_RATE_Y, scale_field(p, 2, 2, 1'b1, 1, 50), 1'b0, 1'b0};
        beats[2] = '{SIG_RATE_Z, scale_field(p, 4, 2, 1'b1, 1, 50), 1'b0, 1'b0};
        n        = 3;
      end
      default: n = 0;
    endcase
    if (n > 0) begin
      seen_mask               = seen_mask | flag;
      done                    = (seen_mask == SEEN_ALL);
      beats[n - 1].last       = 1'b1;
      beats[n - 1].complete   = done;
      if (done) seen_mask = 3'b000;
    end
  endfunction

  // idle length: mostly none, often short, now and then a long stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one frame, wait for its input beat, then queue what it should produce
  task automatic send_frame(input frame_row_t row);
    int        gap;
    int        n;
    sig_beat_t beats [4];
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_id_i <= row.id;
    payload_i  <= row.payload;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    decode_frame(row.id, row.payload, beats, n);
    if (row.typed && n > 0) begin
      beats[n - 1].value    = row.t_value;
      beats[n - 1].complete = row.t_complete;
    end
    for (int k = 0; k < n; k++) pending_signals.push_back(beats[k]);
    frames_sent++;
    if (n == 0) unknown_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit; a hang anywhere ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               pending_signals.size());
      $display("can_sensor_frame_signal_decoder: mismatch");
      $finish;
    end
  end

  // receiver: checks each output beat against the oldest expectation, then picks the stall
  initial begin : sink
    int        stall_left;
    sig_beat_t want;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_signals.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: code %0d value %0d last %0b complete %0b", $time,
                   signal_code_o, value_o, last_o, record_complete_o);
        end else begin
          want = pending_signals.pop_front();
          if (signal_code_o !== want.code) begin
            errors++;
            $display("%0t signal_code: expected %0d got %0d", $time, want.code, signal_code_o);
          end
          if (value_o !== want.value) begin
            errors++;
            $display("%0t value (code %0d): expected %0d got %0d", $time, want.code,
                     want.value, value_o);
          end
          if (last_o !== want.last) begin
            errors++;
            $display("%0t last (code %0d): expected %0b got %0b", $time, want.code,
                     want.last, last_o);
          end
          if (record_complete_o !== want.complete) begin
            errors++;
            $display("%0t record_complete (code %0d): expected %0b got %0b", $time,
                     want.code, want.complete, record_complete_o);
          end
        end
        beats_checked++;
        if (record_complete_o) records_done++;
      end
      // long hold-off so the pipe fills and pushes back on the sender
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left  = pick_gap();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // sender and run control
  initial begin : stimulus
    frame_row_t  row;
    int          idx;
    logic [63:0] p;
    rst_ni     = 1'b0;
    in_valid_i <= 1'b0;
    frame_id_i <= '0;
    payload_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_frame(directed_rows[i]);

    // random frames: mostly known ids, so records keep completing; the rest is noise
    idx = 0;
    while (idx < RANDOM_FRAMES) begin
      calm = (idx >= 100 && idx < 170);
      if (idx == 115) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 3))
          0:       row.id = ID_VEL;
          1:       row.id = ID_DIST;
          2:       row.id = ID_ATT;
          default: row.id = ID_RATE;
        endcase
      end else begin
        row.id = 11'($urandom_range(0, 2047));
      end
      p = {$urandom, $urandom};
      for (int f = 0; f < 4; f++) begin
        if ($urandom_range(0, 3) == 0) p[16 * f +: 16] = FIELD_CORNERS[$urandom_range(0, 5)];
      end
      row.payload    = p;
      row.typed      = 1'b0;
      row.t_value    = '0;
      row.t_complete = 1'b0;
      send_frame(row);
      idx++;
    end
    in_valid_i <= 1'b0;

    while (pending_signals.size() != 0) @(posedge clk_i);
    // let any stray beat show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d frames (%0d with no signals), checked %0d signal beats,", frames_sent,
             unknown_sent, beats_checked);
    $display("saw %0d completed records, %0d errors", records_done, errors);
    if (errors == 0) begin
      $display("can_sensor_frame_signal_decoder: match");
    end else begin
      $display("can_sensor_frame_signal_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> can_sensor_frame_signal_decoder.f
+incdir+src
src/csd_pkg.sv
src/csd_lane.sv
src/csd_merge.sv
src/can_sensor_frame_signal_decoder.sv
src/csd_checker.sv
tb/can_sensor_frame_signal_decoder_test.sv
